// ----- design/crpi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crpi_pkg
// Widths, codes, step schedule and helper functions of the Catmull-Rom
// point interpolator.
// ----------------------------------------------------------------------------
package crpi_pkg;

	localparam int COORD_W  = 16;
	localparam int Z_W      = 24;
	localparam int T_FRAC   = 16;
	localparam int T_W      = T_FRAC + 1;
	localparam int XY_W     = 18;
	localparam int ZO_W     = 26;
	// doubled coefficients need four bits over the widest input
	localparam int COEF_W   = ((Z_W > COORD_W) ? Z_W : COORD_W) + 4;
	localparam int MA_W     = COEF_W;
	localparam int P_W      = MA_W + T_W + 1;
	localparam int XY_ACC_W = COORD_W + 8;
	localparam int ZA_W     = P_W + 2;

	localparam int STEP_W    = 4;
	localparam int N_ISSUE   = 11;
	localparam int MUL_LAT   = 2;
	localparam int LAST_STEP = N_ISSUE + MUL_LAT - 1;

	localparam logic [T_W-1:0]          T_ONE   = T_W'(1) << T_FRAC;
	localparam logic [P_W-1:0]          SQ_RND  = P_W'(1) << (T_FRAC - 1);
	localparam logic signed [P_W-1:0]   TRM_RND = P_W'(1) << T_FRAC;
	localparam logic signed [ZA_W-1:0]  ZA_RND  = ZA_W'(1) << T_FRAC;

	localparam logic signed [XY_ACC_W-1:0] XY_HI = XY_ACC_W'(2 ** (XY_W - 1) - 1);
	localparam logic signed [XY_ACC_W-1:0] XY_LO = XY_ACC_W'(-(2 ** (XY_W - 1)));
	localparam logic signed [ZA_W-1:0]     Z_HI  = ZA_W'(2 ** (ZO_W - 1) - 1);
	localparam logic signed [ZA_W-1:0]     Z_LO  = ZA_W'(-(2 ** (ZO_W - 1)));

	typedef enum logic [1:0] {
		OPC_PUSH  = 2'd0,
		OPC_WRITE = 2'd1,
		OPC_EVAL  = 2'd2
	} opc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_TT,
		K_T2T,
		K_TERM
	} kind_t;

	typedef enum logic [1:0] {
		CRD_X,
		CRD_Y,
		CRD_Z
	} crd_t;

	// CF1 pairs with t, CF2 with t^2, CF3 with t^3
	typedef enum logic [1:0] {
		CF1,
		CF2,
		CF3
	} cf_t;

	typedef struct packed {
		kind_t kind;
		crd_t  crd;
		cf_t   cf;
	} step_t;

	// multiplier issue order; t^2 and t^3 are issued early enough to be back
	// before the terms that use them
	function automatic step_t step_info(input logic [STEP_W-1:0] k);
		step_t s;
		s = '{kind: K_TERM, crd: CRD_X, cf: CF1};
		case (k)
			4'd0:    s = '{kind: K_TT,   crd: CRD_X, cf: CF1};
			4'd1:    s = '{kind: K_TERM, crd: CRD_X, cf: CF1};
			4'd2:    s = '{kind: K_TERM, crd: CRD_Y, cf: CF1};
			4'd3:    s = '{kind: K_T2T,  crd: CRD_X, cf: CF1};
			4'd4:    s = '{kind: K_TERM, crd: CRD_Z, cf: CF1};
			4'd5:    s = '{kind: K_TERM, crd: CRD_X, cf: CF2};
			4'd6:    s = '{kind: K_TERM, crd: CRD_Y, cf: CF2};
			4'd7:    s = '{kind: K_TERM, crd: CRD_Z, cf: CF2};
			4'd8:    s = '{kind: K_TERM, crd: CRD_X, cf: CF3};
			4'd9:    s = '{kind: K_TERM, crd: CRD_Y, cf: CF3};
			4'd10:   s = '{kind: K_TERM, crd: CRD_Z, cf: CF3};
			default: s = '{kind: K_NONE, crd: CRD_X, cf: CF1};
		endcase
		return s;
	endfunction

	// doubled Catmull-Rom coefficients
	function automatic logic signed [COEF_W-1:0] coef_of(
		input cf_t sel,
		input logic signed [COEF_W-1:0] p0,
		input logic signed [COEF_W-1:0] p1,
		input logic signed [COEF_W-1:0] p2,
		input logic signed [COEF_W-1:0] p3
	);
		logic signed [COEF_W-1:0] c;
		case (sel)
			CF3:     c = p3 - p0 + p1 + (p1 <<< 1) - p2 - (p2 <<< 1);
			CF2:     c = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
			default: c = p2 - p0;
		endcase
		return c;
	endfunction

	function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [XY_ACC_W-1:0] v);
		logic signed [XY_ACC_W-1:0] r;
		r = v;
		if (v > XY_HI) r = XY_HI;
		if (v < XY_LO) r = XY_LO;
		return r[XY_W-1:0];
	endfunction

	function automatic logic signed [ZO_W-1:0] sat_z(input logic signed [ZA_W-1:0] v);
		logic signed [ZA_W-1:0] r;
		r = v;
		if (v > Z_HI) r = Z_HI;
		if (v < Z_LO) r = Z_LO;
		return r[ZO_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/crpi_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crpi_in_if
// Command channel: push, write or evaluate words with valid/ready.
// ----------------------------------------------------------------------------
interface crpi_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             operation;
	logic signed [crpi_pkg::COORD_W-1:0]    in_x;
	logic signed [crpi_pkg::COORD_W-1:0]    in_y;
	logic signed [crpi_pkg::Z_W-1:0]        in_z;
	logic [1:0]                             slot;
	logic [crpi_pkg::T_W-1:0]               t_param;

	modport source (
		output valid, operation, in_x, in_y, in_z, slot, t_param,
		input  ready
	);
	modport sink (
		input  valid, operation, in_x, in_y, in_z, slot, t_param,
		output ready
	);
endinterface
`default_nettype wire

// ----- design/crpi_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crpi_out_if
// Result channel: one interpolated point per word with valid/ready.
// ----------------------------------------------------------------------------
interface crpi_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [crpi_pkg::XY_W-1:0]       out_x;
	logic signed [crpi_pkg::XY_W-1:0]       out_y;
	logic signed [crpi_pkg::ZO_W-1:0]       out_z;

	modport source (
		output valid, out_x, out_y, out_z,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z,
		output ready
	);
endinterface
`default_nettype wire

// ----- design/crpi_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crpi_mul
// Shared multiplier: signed coefficient times unsigned power of t, operands
// and product registered.
// ----------------------------------------------------------------------------
module crpi_mul (
	input  wire logic                              clk,
	input  wire logic signed [crpi_pkg::MA_W-1:0]  a,
	input  wire logic [crpi_pkg::T_W-1:0]          b,
	output logic signed [crpi_pkg::P_W-1:0]        prod
);

	logic signed [crpi_pkg::MA_W-1:0] a_s1;
	logic [crpi_pkg::T_W-1:0]         b_s1;
	logic signed [crpi_pkg::P_W-1:0]  prod_s2;

	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		prod_s2 <= crpi_pkg::P_W'(a_s1 * $signed({1'b0, b_s1}));
	end

	assign prod = prod_s2;

endmodule
`default_nettype wire

// ----- design/catmull_rom_point_interpolator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_point_interpolator_unit
// Four-point window with push and slot write; evaluate returns the
// Catmull-Rom cubic at t for x, y (per-term rounding) and z (fixed point).
// ----------------------------------------------------------------------------
//  channel  dir  words
//  cmd      in   operation, in_x, in_y, in_z, slot, t_param
//  res      out  out_x, out_y, out_z (one per evaluate)
//
//  Push and write update the window when accepted. An evaluate holds the
//  block while eleven products (t^2, t^3, nine coefficient terms) go one
//  per cycle through the single two-stage multiplier and drain, then a
//  done state loads the output register. Reset zeroes the window. A result
//  waits there, the next command is taken meanwhile; later ones wait for it.
// ----------------------------------------------------------------------------
module catmull_rom_point_interpolator_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	crpi_in_if.sink     cmd,
	crpi_out_if.source  res
);

	localparam int CW  = crpi_pkg::COORD_W;
	localparam int ZW  = crpi_pkg::Z_W;
	localparam int KW  = crpi_pkg::COEF_W;
	localparam int TW  = crpi_pkg::T_W;
	localparam int PW  = crpi_pkg::P_W;
	localparam int XAW = crpi_pkg::XY_ACC_W;
	localparam int ZAW = crpi_pkg::ZA_W;
	localparam int SW  = crpi_pkg::STEP_W;

	crpi_pkg::state_t state_q, state_d;
	logic [SW-1:0]    step_q;

	logic signed [CW-1:0] win_x_q [4];
	logic signed [CW-1:0] win_y_q [4];
	logic signed [ZW-1:0] win_z_q [4];

	logic [TW-1:0]         t_q, t2_q, t3_q;
	logic signed [XAW-1:0] acc_x_q, acc_y_q;
	logic signed [ZAW-1:0] acc_z_q;

	logic                          res_vld_q;
	logic signed [crpi_pkg::XY_W-1:0] res_x_q, res_y_q;
	logic signed [crpi_pkg::ZO_W-1:0] res_z_q;

	logic accept, out_free, load_res, ret_vld;
	crpi_pkg::step_t iss, ret;

	logic signed [KW-1:0] p0, p1, p2, p3, coef;
	logic signed [crpi_pkg::MA_W-1:0] mul_a;
	logic [TW-1:0]        mul_b, pow;
	logic signed [PW-1:0] prod;
	logic [PW-1:0]        sq_rnd;
	logic signed [PW-1:0] trm_rnd, trm_sh;
	logic signed [XAW-1:0] term;
	logic signed [ZAW-1:0] z_rnd, z_sh;
	logic [TW-1:0]        t_clamp;

	assign cmd.ready = (state_q == crpi_pkg::ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !res_vld_q || res.ready;

	assign res.valid = res_vld_q;
	assign res.out_x = res_x_q;
	assign res.out_y = res_y_q;
	assign res.out_z = res_z_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_res = 1'b0;
		case (state_q)
			crpi_pkg::ST_IDLE: begin
				if (accept && cmd.operation == crpi_pkg::OPC_EVAL) state_d = crpi_pkg::ST_RUN;
			end
			crpi_pkg::ST_RUN: begin
				if (step_q == SW'(crpi_pkg::LAST_STEP)) state_d = crpi_pkg::ST_DONE;
			end
			crpi_pkg::ST_DONE: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = crpi_pkg::ST_IDLE;
				end
			end
			default: state_d = crpi_pkg::ST_IDLE;
		endcase
	end

	// operand selection for the product issued this step
	assign iss     = crpi_pkg::step_info(step_q);
	assign ret     = crpi_pkg::step_info(SW'(step_q - SW'(crpi_pkg::MUL_LAT)));
	assign ret_vld = (state_q == crpi_pkg::ST_RUN) && (step_q >= SW'(crpi_pkg::MUL_LAT));

	always_comb begin
		case (iss.crd)
			crpi_pkg::CRD_Y: begin
				p0 = KW'(win_y_q[0]); p1 = KW'(win_y_q[1]);
				p2 = KW'(win_y_q[2]); p3 = KW'(win_y_q[3]);
			end
			crpi_pkg::CRD_Z: begin
				p0 = KW'(win_z_q[0]); p1 = KW'(win_z_q[1]);
				p2 = KW'(win_z_q[2]); p3 = KW'(win_z_q[3]);
			end
			default: begin
				p0 = KW'(win_x_q[0]); p1 = KW'(win_x_q[1]);
				p2 = KW'(win_x_q[2]); p3 = KW'(win_x_q[3]);
			end
		endcase
		coef = crpi_pkg::coef_of(iss.cf, p0, p1, p2, p3);
		case (iss.cf)
			crpi_pkg::CF3: pow = t3_q;
			crpi_pkg::CF2: pow = t2_q;
			default:       pow = t_q;
		endcase
		case (iss.kind)
			crpi_pkg::K_TT: begin
				mul_a = crpi_pkg::MA_W'(t_q);
				mul_b = t_q;
			end
			crpi_pkg::K_T2T: begin
				mul_a = crpi_pkg::MA_W'(t2_q);
				mul_b = t_q;
			end
			default: begin
				mul_a = coef;
				mul_b = pow;
			end
		endcase
	end

	crpi_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// returning product: power rounding, per-term rounding for x/y
	assign sq_rnd  = PW'(prod) + crpi_pkg::SQ_RND;
	assign trm_rnd = prod + crpi_pkg::TRM_RND;
	assign trm_sh  = trm_rnd >>> (crpi_pkg::T_FRAC + 1);
	assign term    = trm_sh[XAW-1:0];
	assign t_clamp = (cmd.t_param > crpi_pkg::T_ONE) ? crpi_pkg::T_ONE : cmd.t_param;

	assign z_rnd = acc_z_q + crpi_pkg::ZA_RND;
	assign z_sh  = z_rnd >>> (crpi_pkg::T_FRAC + 1);

	// window, registered with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				win_x_q[i] <= '0;
				win_y_q[i] <= '0;
				win_z_q[i] <= '0;
			end
		end else if (accept) begin
			case (cmd.operation)
				crpi_pkg::OPC_PUSH: begin
					for (int i = 0; i < 3; i++) begin
						win_x_q[i] <= win_x_q[i+1];
						win_y_q[i] <= win_y_q[i+1];
						win_z_q[i] <= win_z_q[i+1];
					end
					win_x_q[3] <= cmd.in_x;
					win_y_q[3] <= cmd.in_y;
					win_z_q[3] <= cmd.in_z;
				end
				crpi_pkg::OPC_WRITE: begin
					win_x_q[cmd.slot] <= cmd.in_x;
					win_y_q[cmd.slot] <= cmd.in_y;
					win_z_q[cmd.slot] <= cmd.in_z;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (accept) step_q <= '0;
			else if (state_q == crpi_pkg::ST_RUN) step_q <= step_q + SW'(1);
			if (load_res) res_vld_q <= 1'b1;
			else if (res.ready) res_vld_q <= 1'b0;
		end
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		if (accept && cmd.operation == crpi_pkg::OPC_EVAL) begin
			t_q     <= t_clamp;
			acc_x_q <= XAW'(win_x_q[1]);
			acc_y_q <= XAW'(win_y_q[1]);
			acc_z_q <= ZAW'(win_z_q[1]) <<< (crpi_pkg::T_FRAC + 1);
		end else if (ret_vld) begin
			case (ret.kind)
				crpi_pkg::K_TT:  t2_q <= sq_rnd[crpi_pkg::T_FRAC +: TW];
				crpi_pkg::K_T2T: t3_q <= sq_rnd[crpi_pkg::T_FRAC +: TW];
				crpi_pkg::K_TERM: begin
					case (ret.crd)
						crpi_pkg::CRD_X: acc_x_q <= acc_x_q + term;
						crpi_pkg::CRD_Y: acc_y_q <= acc_y_q + term;
						default:         acc_z_q <= acc_z_q + ZAW'(prod);
					endcase
				end
				default: ;
			endcase
		end
		if (load_res) begin
			res_x_q <= crpi_pkg::sat_xy(acc_x_q);
			res_y_q <= crpi_pkg::sat_xy(acc_y_q);
			res_z_q <= crpi_pkg::sat_z(z_sh);
		end
	end

endmodule
`default_nettype wire
